@@ sv/coilw_pkg.sv @@
// coilw_pkg: types, constants and register indexes of the debounced coil writer.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package coilw_pkg;

    localparam int CH_MAX       = 8;
    localparam int DEF_CHANNELS = 8;

    localparam int TIME_W  = 32;
    localparam int MS_W    = 16;
    localparam int ATT_W   = 3;
    localparam int CH_W    = 3;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DATA_W = 16;

    localparam logic [MS_W-1:0]  POLL_RESET     = 16'd50;
    localparam logic [MS_W-1:0]  DEBOUNCE_RESET = 16'd30;
    localparam logic [ATT_W-1:0] ATTEMPTS_RESET = 3'd3;
    localparam logic [MS_W-1:0]  BASE_RESET     = 16'd0;

    localparam logic [CFG_IDX_W-1:0] REG_POLL     = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ATTEMPTS = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BASE     = 4'd3;

    localparam logic CMD_SAMPLE  = 1'b0;
    localparam logic CMD_OUTCOME = 1'b1;

    localparam logic KIND_REQUEST = 1'b0;
    localparam logic KIND_ABANDON = 1'b1;

    typedef struct packed {
        logic              cmd;
        logic [TIME_W-1:0] now_ms;
        logic [CH_MAX-1:0] pin_levels;
        logic [CH_W-1:0]   outcome_channel;
        logic              write_ok;
    } in_word_t;

    typedef struct packed {
        logic             kind;
        logic [CH_W-1:0]  channel;
        logic [MS_W-1:0]  coil_address;
        logic             coil_value;
        logic [ATT_W-1:0] attempt;
        logic             last;
    } out_word_t;

    typedef struct packed {
        logic              prime;
        logic              sample_go;
        logic              outcome_go;
        logic              write_ok;
        logic              pin;
        logic [TIME_W-1:0] now_ms;
        logic [MS_W-1:0]   stable_ms;
        logic [ATT_W-1:0]  max_attempts;
    } lane_ctl_t;

    typedef struct packed {
        logic             emit;
        logic             kind;
        logic             value;
        logic [ATT_W-1:0] attempt;
    } lane_res_t;

endpackage

`default_nettype wire

@@ sv/coilw_lane.sv @@
// coilw_lane: per-channel debounce and write-retry state of one channel.
// Depends on coilw_pkg for the control and result structs.
`timescale 1ns / 1ps
`default_nettype none

module coilw_lane (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire coilw_pkg::lane_ctl_t ctl,
    output coilw_pkg::lane_res_t    res
);
    import coilw_pkg::*;

    logic              raw_level_reg, raw_level_next;
    logic [TIME_W-1:0] change_time_reg, change_time_next;
    logic              sent_value_reg, sent_value_next;
    logic              pending_reg, pending_next;
    logic              pending_value_reg, pending_value_next;
    logic [ATT_W-1:0]  attempt_count_reg, attempt_count_next;

    logic              raw;
    logic [TIME_W-1:0] elapsed;
    logic              settled;

    assign raw     = ~ctl.pin;
    assign elapsed = ctl.now_ms - change_time_reg;
    assign settled = elapsed >= {{(TIME_W-MS_W){1'b0}}, ctl.stable_ms};

    always_comb
    begin
        raw_level_next     = raw_level_reg;
        change_time_next   = change_time_reg;
        sent_value_next    = sent_value_reg;
        pending_next       = pending_reg;
        pending_value_next = pending_value_reg;
        attempt_count_next = attempt_count_reg;
        res.emit    = 1'b0;
        res.kind    = KIND_REQUEST;
        res.value   = raw;
        res.attempt = ATT_W'(1);

        if (ctl.prime)
        begin
            raw_level_next     = raw;
            change_time_next   = ctl.now_ms;
            sent_value_next    = ~raw;
            pending_next       = 1'b1;
            pending_value_next = raw;
            attempt_count_next = ATT_W'(1);
            res.emit           = 1'b1;
        end
        else if (ctl.sample_go)
        begin
            if (raw != raw_level_reg)
            begin
                raw_level_next   = raw;
                change_time_next = ctl.now_ms;
            end
            else if (settled && raw != sent_value_reg && !pending_reg)
            begin
                pending_next       = 1'b1;
                pending_value_next = raw;
                attempt_count_next = ATT_W'(1);
                res.emit           = 1'b1;
            end
        end
        else if (ctl.outcome_go && pending_reg)
        begin
            res.value = pending_value_reg;
            if (ctl.write_ok)
            begin
                sent_value_next    = pending_value_reg;
                pending_next       = 1'b0;
                attempt_count_next = '0;
            end
            else if (attempt_count_reg < ctl.max_attempts)
            begin
                attempt_count_next = attempt_count_reg + ATT_W'(1);
                res.emit           = 1'b1;
                res.attempt        = attempt_count_next;
            end
            else
            begin
                res.emit           = 1'b1;
                res.kind           = KIND_ABANDON;
                res.attempt        = attempt_count_reg;
                pending_next       = 1'b0;
                attempt_count_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_level_reg     <= 1'b0;
            change_time_reg   <= '0;
            sent_value_reg    <= 1'b0;
            pending_reg       <= 1'b0;
            attempt_count_reg <= '0;
        end
        else
        begin
            raw_level_reg     <= raw_level_next;
            change_time_reg   <= change_time_next;
            sent_value_reg    <= sent_value_next;
            pending_reg       <= pending_next;
            attempt_count_reg <= attempt_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pending_value_reg <= pending_value_next;
    end

endmodule

`default_nettype wire

@@ sv/coilw_merge.sv @@
// coilw_merge: holds one item's lane results; drains one word a cycle unless stalled.
// Depends on coilw_pkg for the lane result and output word types.
`timescale 1ns / 1ps
`default_nettype none

module coilw_merge #(
    parameter int LANES = coilw_pkg::DEF_CHANNELS
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 load,
    input  wire coilw_pkg::lane_res_t lane_res [LANES],
    input  wire logic [coilw_pkg::MS_W-1:0] coil_base,
    output logic                      free,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output coilw_pkg::out_word_t      out_word
);
    import coilw_pkg::*;

    localparam int SEL_W = (LANES > 1) ? $clog2(LANES) : 1;

    logic [LANES-1:0] mask_reg, mask_next;
    lane_res_t        res_reg [LANES];
    logic             out_valid_reg;
    out_word_t        out_reg;

    logic [SEL_W-1:0] sel;
    logic [LANES-1:0] remaining;
    logic             adv;
    logic             found;
    lane_res_t        pick;

    always_comb
    begin
        sel   = '0;
        found = 1'b0;
        for (int i = 0; i < LANES; i++)
        begin
            if (mask_reg[i] && !found)
            begin
                sel   = SEL_W'(i);
                found = 1'b1;
            end
        end
    end

    always_comb
    begin
        remaining      = mask_reg;
        remaining[sel] = 1'b0;
    end

    assign pick = res_reg[sel];
    assign adv  = (mask_reg != '0) && (!out_valid_reg || out_ready);
    assign free = (mask_reg == '0) || (adv && remaining == '0);

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            mask_next[i] = lane_res[i].emit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                mask_reg <= mask_next;
            end
            else if (adv)
            begin
                mask_reg <= remaining;
            end
            if (adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= lane_res;
        end
        if (adv)
        begin
            out_reg.kind         <= pick.kind;
            out_reg.channel      <= CH_W'(sel);
            out_reg.coil_address <= coil_base + MS_W'(sel);
            out_reg.coil_value   <= pick.value;
            out_reg.attempt      <= pick.attempt;
            out_reg.last         <= (remaining == '0);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

endmodule

`default_nettype wire

@@ sv/debounced_input_coil_writer.sv @@
// debounced_input_coil_writer: top level with configuration registers, poll pacing,
// one coilw_lane per channel and the coilw_merge output stage. Depends on coilw_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Each accepted word is evaluated by all channel lanes in the cycle it is taken;
// the merge stage then delivers its results, lowest channel first, one word per
// cycle while out_ready allows, with last set on the final one. A pin sample can
// yield up to one write request per channel, a write outcome at most one word,
// and a word that yields nothing is taken every cycle. The next input word is
// taken in the cycle the previous item's final result moves to the output
// register, so the output drain rate of the merge stage sets the throughput.
// Channels above eight are clipped to the width of pin_levels.
module debounced_input_coil_writer #(
    parameter int CHANNELS = coilw_pkg::DEF_CHANNELS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire coilw_pkg::in_word_t           in_word,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output coilw_pkg::out_word_t               out_word,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [coilw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [coilw_pkg::CFG_DATA_W-1:0] cfg_data
);
    import coilw_pkg::*;

    localparam int NCH = (CHANNELS < CH_MAX) ? CHANNELS : CH_MAX;

    logic [MS_W-1:0]   poll_reg;
    logic [MS_W-1:0]   debounce_reg;
    logic [ATT_W-1:0]  attempts_reg;
    logic [MS_W-1:0]   base_reg;
    logic [TIME_W-1:0] last_poll_reg;
    logic              primed_reg;

    logic              accept;
    logic              sample_acc;
    logic              prime;
    logic              sample_go;
    logic              outcome_acc;
    logic              pace_ok;
    logic [TIME_W-1:0] since_poll;
    logic              free;

    lane_ctl_t         ctl [NCH];
    lane_res_t         res [NCH];

    assign cfg_ready  = 1'b1;
    assign in_ready   = free;
    assign accept     = in_valid && free;
    assign since_poll = in_word.now_ms - last_poll_reg;
    assign pace_ok    = since_poll >= {{(TIME_W-MS_W){1'b0}}, poll_reg};
    assign sample_acc = accept && (in_word.cmd == CMD_SAMPLE);
    assign prime      = sample_acc && !primed_reg;
    assign sample_go  = sample_acc && primed_reg && pace_ok;
    assign outcome_acc = accept && (in_word.cmd == CMD_OUTCOME)
                         && ({1'b0, in_word.outcome_channel} < (CH_W+1)'(NCH));

    always_comb
    begin
        for (int i = 0; i < NCH; i++)
        begin
            ctl[i].prime        = prime;
            ctl[i].sample_go    = sample_go;
            ctl[i].outcome_go   = outcome_acc && (in_word.outcome_channel == CH_W'(i));
            ctl[i].write_ok     = in_word.write_ok;
            ctl[i].pin          = in_word.pin_levels[i];
            ctl[i].now_ms       = in_word.now_ms;
            ctl[i].stable_ms    = debounce_reg;
            ctl[i].max_attempts = attempts_reg;
        end
    end

    for (genvar g = 0; g < NCH; g++)
    begin : g_lane
        coilw_lane u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .ctl   (ctl[g]),
            .res   (res[g])
        );
    end

    coilw_merge #(
        .LANES (NCH)
    ) u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .lane_res  (res),
        .coil_base (base_reg),
        .free      (free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poll_reg      <= POLL_RESET;
            debounce_reg  <= DEBOUNCE_RESET;
            attempts_reg  <= ATTEMPTS_RESET;
            base_reg      <= BASE_RESET;
            last_poll_reg <= '0;
            primed_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_POLL:     poll_reg     <= cfg_data;
                    REG_DEBOUNCE: debounce_reg <= cfg_data;
                    REG_ATTEMPTS: attempts_reg <= cfg_data[ATT_W-1:0];
                    REG_BASE:     base_reg     <= cfg_data;
                    default:      ;
                endcase
            end
            if (prime || sample_go)
            begin
                last_poll_reg <= in_word.now_ms;
            end
            if (prime)
            begin
                primed_reg <= 1'b1;
            end
        end
    end

endmodule

`default_nettype wire
